### rtl/upq_pkg.sv
// Package for the urgency priority queue: record layout, action and status codes,
// sequencer states and size constants.
// Used by urgency_priority_queue; depends on nothing else.
`timescale 1ns / 1ps

package upq_pkg;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned TicketW    = 5;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_LIST = 2'd1,
    ACT_DEQ  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Record packing: id in the lowest bits, urgency in the highest.
  typedef struct packed {
    logic [2:0]  urgency;
    logic [1:0]  insurance;
    logic [1:0]  sex;
    logic [7:0]  age;
    logic [15:0] patient_id;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_SWP,
    S_LIST_RD,
    S_LIST_LD,
    S_DEQ_LD,
    S_EMIT
  } state_e;

endpackage

### rtl/urgency_priority_queue.sv
// Top level of the urgency priority queue: record memory, sequencer with one shared
// urgency comparator, and the output register.
// Depends on upq_pkg.
`timescale 1ns / 1ps

// Channel  Direction  Beat
// s_axis   in         tuser = action, tdata = record to enqueue
// m_axis   out        tuser = status, tdata = ticket and record, tlast = last result
//
// Enqueue writes the record and goes to the emit state; dequeue reads the head slot
// and loads it first; action 3 is taken and dropped. Sort reads both slots of a pair
// in one memory read, makes one urgency compare and up to two single-port writes for
// a swap; list then reads, loads and emits each record. Reset clears the state,
// pointers, counters and output valid; the record memory needs no clearing. A stalled
// output holds the sequencer in its emit state; the input is taken again once idle.

module urgency_priority_queue #(
  parameter int unsigned CAPACITY = upq_pkg::Capacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] patient_id, [23:16] age_years, [25:24] sex_code,
  // [27:26] insurance_code, [30:28] urgency, [31] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] ticket, [20:5] out_patient_id, [28:21] out_age, [30:29] out_sex,
  // [32:31] out_insurance, [35:33] out_urgency, [39:36] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned TW = upq_pkg::TicketW;

  upq_pkg::rec_t mem_q [CAPACITY];
  upq_pkg::rec_t rd_a_q, rd_b_q;
  logic          rd_en;
  logic [IW-1:0] rd_addr_a, rd_addr_b;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  upq_pkg::rec_t wr_data;

  upq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]   i_q, i_d, j_q, j_d;
  logic [CW-1:0]   n_q, n_d, cnt_q, cnt_d;
  logic            listing_q, listing_d;

  upq_pkg::status_e st_status_q, st_status_d;
  logic [TW-1:0]    st_ticket_q, st_ticket_d;
  upq_pkg::rec_t    st_rec_q, st_rec_d;
  logic             st_last_q, st_last_d;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  upq_pkg::status_e out_status_q;
  logic [TW-1:0]    out_ticket_q;
  upq_pkg::rec_t    out_rec_q;
  logic             out_last_q;

  logic          in_fire;
  logic [CW-1:0] live, slot;
  logic [CW:0]   slot_inc, tail_inc, head_inc;

  assign s_axis_tready = (state_q == upq_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign live          = tail_q - head_q;
  assign slot          = head_q + n_q;
  assign slot_inc      = {1'b0, slot} + (CW + 1)'(1);
  assign tail_inc      = {1'b0, tail_q} + (CW + 1)'(1);
  assign head_inc      = {1'b0, head_q} + (CW + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    listing_d   = listing_q;
    st_status_d = st_status_q;
    st_ticket_d = st_ticket_q;
    st_rec_d    = st_rec_q;
    st_last_d   = st_last_q;
    rd_en       = 1'b0;
    rd_addr_a   = i_q[IW-1:0];
    rd_addr_b   = j_q[IW-1:0];
    wr_en       = 1'b0;
    wr_addr     = tail_q[IW-1:0];
    wr_data     = upq_pkg::rec_t'(s_axis_tdata[30:0]);
    out_load    = 1'b0;

    case (state_q)
      upq_pkg::S_IDLE: begin
        if (in_fire) begin
          st_last_d = 1'b1;
          listing_d = 1'b0;
          case (s_axis_tuser)
            upq_pkg::ACT_ENQ: begin
              state_d = upq_pkg::S_EMIT;
              if (tail_q == CW'(CAPACITY)) begin
                st_status_d = upq_pkg::ST_FULL;
                st_ticket_d = '0;
                st_rec_d    = '0;
              end else begin
                wr_en       = 1'b1;
                tail_d      = tail_q + CW'(1);
                st_status_d = upq_pkg::ST_OK;
                st_ticket_d = TW'(tail_inc);
                st_rec_d    = upq_pkg::rec_t'(s_axis_tdata[30:0]);
              end
            end
            upq_pkg::ACT_LIST: begin
              if (head_q == tail_q) begin
                state_d     = upq_pkg::S_EMIT;
                st_status_d = upq_pkg::ST_EMPTY;
                st_ticket_d = '0;
                st_rec_d    = '0;
              end else begin
                i_d   = head_q;
                j_d   = head_q + CW'(1);
                n_d   = '0;
                cnt_d = (int'(live) > upq_pkg::MaxResults) ?
                        CW'(upq_pkg::MaxResults) : live;
                state_d = (live == CW'(1)) ? upq_pkg::S_LIST_RD : upq_pkg::S_SORT_RD;
              end
            end
            upq_pkg::ACT_DEQ: begin
              if (head_q == tail_q) begin
                state_d     = upq_pkg::S_EMIT;
                st_status_d = upq_pkg::ST_EMPTY;
                st_ticket_d = '0;
                st_rec_d    = '0;
              end else begin
                rd_en       = 1'b1;
                rd_addr_a   = head_q[IW-1:0];
                head_d      = head_q + CW'(1);
                st_status_d = upq_pkg::ST_OK;
                st_ticket_d = TW'(head_inc);
                state_d     = upq_pkg::S_DEQ_LD;
              end
            end
            default: begin
              state_d = upq_pkg::S_IDLE;
            end
          endcase
        end
      end
      upq_pkg::S_SORT_RD: begin
        rd_en   = 1'b1;
        state_d = upq_pkg::S_SORT_CMP;
      end
      upq_pkg::S_SORT_CMP, upq_pkg::S_SORT_SWP: begin
        if ((state_q == upq_pkg::S_SORT_CMP) && (rd_a_q.urgency < rd_b_q.urgency)) begin
          wr_en   = 1'b1;
          wr_addr = i_q[IW-1:0];
          wr_data = rd_b_q;
          state_d = upq_pkg::S_SORT_SWP;
        end else begin
          if (state_q == upq_pkg::S_SORT_SWP) begin
            wr_en   = 1'b1;
            wr_addr = j_q[IW-1:0];
            wr_data = rd_a_q;
          end
          if ((j_q + CW'(1)) < tail_q) begin
            j_d     = j_q + CW'(1);
            state_d = upq_pkg::S_SORT_RD;
          end else if ((i_q + CW'(2)) < tail_q) begin
            i_d     = i_q + CW'(1);
            j_d     = i_q + CW'(2);
            state_d = upq_pkg::S_SORT_RD;
          end else begin
            state_d = upq_pkg::S_LIST_RD;
          end
        end
      end
      upq_pkg::S_LIST_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = slot[IW-1:0];
        state_d   = upq_pkg::S_LIST_LD;
      end
      upq_pkg::S_LIST_LD: begin
        listing_d   = 1'b1;
        st_status_d = upq_pkg::ST_OK;
        st_ticket_d = TW'(slot_inc);
        st_rec_d    = rd_a_q;
        st_last_d   = ((n_q + CW'(1)) == cnt_q);
        state_d     = upq_pkg::S_EMIT;
      end
      upq_pkg::S_DEQ_LD: begin
        st_rec_d = rd_a_q;
        state_d  = upq_pkg::S_EMIT;
      end
      upq_pkg::S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          if (listing_q && !st_last_q) begin
            n_d     = n_q + CW'(1);
            state_d = upq_pkg::S_LIST_RD;
          end else begin
            state_d = upq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = upq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= upq_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      listing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      listing_q   <= listing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_status_q <= st_status_d;
    st_ticket_q <= st_ticket_d;
    st_rec_q    <= st_rec_d;
    st_last_q   <= st_last_d;
    if (out_load) begin
      out_status_q <= st_status_q;
      out_ticket_q <= st_ticket_q;
      out_rec_q    <= st_rec_q;
      out_last_q   <= st_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0000, out_rec_q.urgency, out_rec_q.insurance, out_rec_q.sex,
                          out_rec_q.age, out_rec_q.patient_id, out_ticket_q};

endmodule
